// ----- design/assert_macros.svh -----
// assertion helpers included by the top-level unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define TKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tks assertion failed");

// same-cycle implication
`define TKS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tks implication failed");

// next-cycle implication
`define TKS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tks sequence failed");

`else

`define TKS_ASSERT(lbl, clk, rstn, prop)
`define TKS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TKS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/tks_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants of the top-k running sum unit: sizes, the cell
// command carried along the sorted row and the sequencer states.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MAX_KEEP = 64;
  localparam int VALUE_W  = 32;
  localparam int SUM_W    = 38;
  localparam int COUNT_W  = $clog2(MAX_KEEP + 1);
  localparam int KEEP_W   = 7;
  localparam int DELTA_W  = VALUE_W + 1;

  typedef logic signed [VALUE_W-1:0] value_t;

  // command applied to every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REPLACE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    value_t   value;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_DONE
  } tks_state_e;

endpackage
`default_nettype wire

// ----- design/tks_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the ascending sorted row. Compares its value with the offered
// value and takes its own, the offered or a neighbor's value.
// ----------------------------------------------------------------------------
module tks_cell (
  input  wire logic                clk_i,
  input  wire tks_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                occ_i,
  input  wire logic                tail_i,
  input  wire logic                prev_gt_i,
  input  wire tks_pkg::value_t     prev_val_i,
  input  wire logic                next_lt_i,
  input  wire tks_pkg::value_t     next_val_i,
  output tks_pkg::value_t          val_o,
  output logic                     gt_o,
  output logic                     lt_o
);
  import tks_pkg::*;

  value_t val_q, val_d;

  // compare flags seen by the neighbors
  assign gt_o  = occ_i && ($signed(val_q) > $signed(ctrl_i.value));
  assign lt_o  = occ_i && ($signed(val_q) < $signed(ctrl_i.value));
  assign val_o = val_q;

  // insert shifts larger values up, replace shifts smaller values down
  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (prev_gt_i) begin
          val_d = prev_val_i;
        end else if (gt_o || tail_i) begin
          val_d = ctrl_i.value;
        end
      end
      CELL_REPLACE: begin
        if (next_lt_i) begin
          val_d = next_val_i;
        end else if (lt_o) begin
          val_d = ctrl_i.value;
        end
      end
      default: val_d = val_q;
    endcase
  end

  // value register
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// ----- design/tks_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_chain
// Row of sorting cells, smallest value in cell zero. Wires each cell to its
// neighbors and derives occupancy from the held count.
// ----------------------------------------------------------------------------
module tks_chain (
  input  wire logic                          clk_i,
  input  wire tks_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [tks_pkg::COUNT_W-1:0]   held_i,
  output tks_pkg::value_t                    min_o
);
  import tks_pkg::*;

  value_t val   [MAX_KEEP];
  logic   gt    [MAX_KEEP];
  logic   lt    [MAX_KEEP];

  assign min_o = val[0];

  // one cell per slot, data handed to the neighbors every cycle
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic   prev_gt;
    value_t prev_val;
    logic   next_lt;
    value_t next_val;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_mid_lo
      assign prev_gt  = gt[i-1];
      assign prev_val = val[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_last
      assign next_lt  = 1'b0;
      assign next_val = '0;
    end else begin : g_mid_hi
      assign next_lt  = lt[i+1];
      assign next_val = val[i+1];
    end

    tks_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .occ_i      (held_i > COUNT_W'(i)),
      .tail_i     (held_i == COUNT_W'(i)),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_lt_i  (next_lt),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .gt_o       (gt[i]),
      .lt_o       (lt[i])
    );
  end

endmodule
`default_nettype wire

// ----- design/top_k_running_sum_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_running_sum_unit
// Keeps the k largest signed values offered so far in a sorted row of cells
// and reports their running sum and the held count after every value.
// ----------------------------------------------------------------------------
//  channel   signals                        transfer when
//  command   start_i, busy_o, value_i       start_i high, busy_o low
//  result    done_o, top_sum_o, held_o      done_o high (one cycle)
//  config    cfg_valid_i, cfg_ready_o,      cfg_valid_i and cfg_ready_o high
//            cfg_data_i
//
// After its start transfer each value passes the cell row update and delta
// register, then the sum add, then the result strobe. A new start may be
// taken in the strobe cycle; starts are refused during the update and add.
// Sum, held count and state clear on reset; keep count resets to 64.
// The cells hold no reset; only slots below the held count are ever used.
// The result cannot be stalled; it is shown for one cycle only.
// ----------------------------------------------------------------------------
module top_k_running_sum_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic signed [tks_pkg::VALUE_W-1:0]   value_i,
  output logic                                      done_o,
  output logic signed [tks_pkg::SUM_W-1:0]          top_sum_o,
  output logic [tks_pkg::COUNT_W-1:0]               held_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [tks_pkg::KEEP_W-1:0]           cfg_data_i
);
  import tks_pkg::*;

`include "assert_macros.svh"

  tks_state_e              state_q, state_d;
  value_t                  value_q;
  logic [KEEP_W-1:0]       keep_q;
  logic [COUNT_W-1:0]      held_q, held_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic                    upd_q, upd_d;
  logic [COUNT_W-1:0]      eff_keep;
  logic                    full;
  logic                    take;
  cell_ctrl_t              ctrl;
  value_t                  min_val;

  assign take        = start_i && !busy_o;
  assign busy_o      = (state_q == ST_SHIFT) || (state_q == ST_SUM);
  assign cfg_ready_o = !busy_o;
  assign done_o      = (state_q == ST_DONE);
  assign top_sum_o   = sum_q;
  assign held_o      = held_q;

  // keep count clamped to one .. MAX_KEEP
  always_comb begin
    if (keep_q == '0) begin
      eff_keep = COUNT_W'(1);
    end else if (COUNT_W'(keep_q) > COUNT_W'(MAX_KEEP)) begin
      eff_keep = COUNT_W'(MAX_KEEP);
    end else begin
      eff_keep = COUNT_W'(keep_q);
    end
  end

  assign full = (held_q >= eff_keep);

  // sorted row of cells
  tks_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .held_i (held_q),
    .min_o  (min_val)
  );

  // sequencer: next state, cell command and sum delta
  always_comb begin
    state_d    = state_q;
    ctrl.op    = CELL_HOLD;
    ctrl.value = value_q;
    held_d     = held_q;
    delta_d    = delta_q;
    upd_d      = upd_q;
    sum_d      = sum_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        state_d = ST_SUM;
        if (!full) begin
          ctrl.op = CELL_INSERT;
          held_d  = held_q + COUNT_W'(1);
          delta_d = DELTA_W'(value_q);
          upd_d   = 1'b1;
        end else if ($signed(value_q) > $signed(min_val)) begin
          ctrl.op = CELL_REPLACE;
          delta_d = DELTA_W'(value_q) - DELTA_W'(min_val);
          upd_d   = 1'b1;
        end else begin
          upd_d   = 1'b0;
        end
      end
      ST_SUM: begin
        state_d = ST_DONE;
        if (upd_q) begin
          sum_d = sum_q + SUM_W'(delta_q);
        end
      end
      ST_DONE: begin
        state_d = take ? ST_SHIFT : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      sum_q   <= '0;
      keep_q  <= KEEP_W'(MAX_KEEP);
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      sum_q   <= sum_d;
      upd_q   <= upd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        keep_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      value_q <= value_i;
    end
    delta_q <= delta_d;
  end

  // checks
  `TKS_ASSERT(a_held_bound, clk_i, rst_ni, held_q <= COUNT_W'(MAX_KEEP))
  `TKS_ASSERT_NXT(a_start_shift, clk_i, rst_ni, take, state_q == ST_SHIFT)
  `TKS_ASSERT_IMP(a_done_after_sum, clk_i, rst_ni, done_o, $past(state_q) == ST_SUM)
  `TKS_ASSERT_NXT(a_held_step, clk_i, rst_ni, 1'b1, held_q - $past(held_q) <= COUNT_W'(1))

endmodule
`default_nettype wire
